FILE: hdl/wsh_pkg.sv
// Shared types, constants and helpers for the 64-bit word stream hash.
`default_nettype none

package wsh_pkg;

   localparam logic [31:0] HASH_MULT = 32'h5bd1e995;

   localparam int unsigned MIX_SHIFT = 24;
   localparam int unsigned FIN_SHIFT_A = 18;
   localparam int unsigned FIN_SHIFT_B = 22;
   localparam int unsigned FIN_SHIFT_C = 17;
   localparam int unsigned FIN_SHIFT_D = 19;

   typedef enum logic [1:0] {
      OP_NONE = 2'd0,
      OP_TAIL = 2'd1,
      OP_FULL = 2'd2
   } op_kind_type;

   typedef struct packed {
      op_kind_type kind;
      logic        first;
      logic        last;
      logic [31:0] start_value;
      logic [31:0] operand;
   } queue_entry_type;

   // Keep the low bytes of a partial word (1 to 3 bytes).
   function automatic logic [31:0] tail_mask(input logic [1:0] bytes);
      logic [31:0] mask;
      unique case (bytes)
         2'd1:    mask = 32'h0000_00ff;
         2'd2:    mask = 32'h0000_ffff;
         2'd3:    mask = 32'h00ff_ffff;
         default: mask = 32'h0000_0000;
      endcase
      return mask;
   endfunction

endpackage

`default_nettype wire

FILE: hdl/wsh_front.sv
// Front end: accepts words, classifies them and premixes full words.
`default_nettype none

module wsh_front
   import wsh_pkg::*;
(
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic [31:0]     seed,
   input  wire logic [31:0]     req_data_word,
   input  wire logic [2:0]      req_byte_count,
   input  wire logic            req_first_item,
   input  wire logic            req_last_item,
   input  wire logic [30:0]     req_total_length,
   input  wire logic            req_valid,
   output logic                 req_stall,
   input  wire logic            queue_full,
   output logic                 queue_push,
   output queue_entry_type      queue_entry
);

   typedef enum logic [2:0] {
      F_IDLE = 3'b001,
      F_MUL  = 3'b010,
      F_PUSH = 3'b100
   } front_state_type;

   front_state_type state_ff, state_in;

   logic [31:0] word_ff, word_in;
   logic [31:0] prod_ff, prod_in;
   logic [31:0] start_ff, start_in;
   logic [1:0]  count_ff, count_in;
   op_kind_type kind_ff, kind_in;
   logic        first_ff, first_in;
   logic        last_ff, last_in;

   logic        ready;
   logic        accept;
   logic [31:0] premix;
   logic [31:0] mixed;

   assign ready = (state_ff == F_IDLE) || ((state_ff == F_PUSH) && !queue_full);
   assign accept = req_valid && ready;
   assign req_stall = !ready;
   assign queue_push = (state_ff == F_PUSH) && !queue_full;

   assign premix = prod_ff ^ (prod_ff >> MIX_SHIFT);
   assign mixed = premix * HASH_MULT;

   always_comb begin
      queue_entry.kind = kind_ff;
      queue_entry.first = first_ff;
      queue_entry.last = last_ff;
      queue_entry.start_value = start_ff;
      queue_entry.operand = (kind_ff == OP_FULL) ? mixed : (word_ff & tail_mask(count_ff));
   end

   always_comb begin
      state_in = state_ff;
      word_in = word_ff;
      prod_in = prod_ff;
      start_in = start_ff;
      count_in = count_ff;
      kind_in = kind_ff;
      first_in = first_ff;
      last_in = last_ff;

      if (accept) begin
         word_in = req_data_word;
         count_in = req_byte_count[1:0];
         first_in = req_first_item;
         last_in = req_last_item;
         start_in = seed ^ {1'b0, req_total_length};
         if (req_byte_count[2]) begin
            kind_in = OP_FULL;
         end else if (req_byte_count[1:0] != 2'd0) begin
            kind_in = OP_TAIL;
         end else begin
            kind_in = OP_NONE;
         end
      end

      if (state_ff == F_MUL) begin
         prod_in = word_ff * HASH_MULT;
      end

      unique case (state_ff)
         F_IDLE: begin
            if (accept) begin
               state_in = F_MUL;
            end
         end
         F_MUL: begin
            state_in = F_PUSH;
         end
         F_PUSH: begin
            if (!queue_full) begin
               state_in = accept ? F_MUL : F_IDLE;
            end
         end
         default: begin
            state_in = F_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= F_IDLE;
      end else begin
         state_ff <= state_in;
      end
      word_ff <= word_in;
      prod_ff <= prod_in;
      start_ff <= start_in;
      count_ff <= count_in;
      kind_ff <= kind_in;
      first_ff <= first_in;
      last_ff <= last_in;
   end

endmodule

`default_nettype wire

FILE: hdl/wsh_queue.sv
// Short FIFO of classified words between the front and back ends.
`default_nettype none

module wsh_queue
   import wsh_pkg::*;
#(
   parameter int unsigned DEPTH = 2
) (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            push,
   input  wire queue_entry_type push_entry,
   output logic                 full,
   input  wire logic            pop,
   output logic                 head_valid,
   output queue_entry_type      head_entry
);

   localparam int unsigned IdxW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CntW = $clog2(DEPTH + 1);

   queue_entry_type entries_ff [DEPTH];

   logic [IdxW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [IdxW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0] count_ff, count_in;

   assign full = (count_ff == CntW'(DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_entry = entries_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == IdxW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == IdxW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

`default_nettype wire

FILE: hdl/wsh_back.sv
// Back end: accumulator recurrence, finalization and result register.
`default_nettype none

module wsh_back
   import wsh_pkg::*;
(
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            head_valid,
   input  wire queue_entry_type head_entry,
   output logic                 pop,
   output logic                 rsp_valid,
   input  wire logic            rsp_stall,
   output logic [63:0]          rsp_hash_value
);

   typedef enum logic [2:0] {
      B_IDLE = 3'b001,
      B_FIN  = 3'b010,
      B_EMIT = 3'b100
   } back_state_type;

   localparam logic [1:0] LAST_STEP = 2'd3;

   back_state_type state_ff, state_in;

   logic [31:0] acc_high_ff, acc_high_in;
   logic [31:0] acc_low_ff, acc_low_in;
   logic        parity_ff, parity_in;
   logic [31:0] fin_high_ff, fin_high_in;
   logic [31:0] fin_low_ff, fin_low_in;
   logic [1:0]  step_ff, step_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [63:0] hash_ff, hash_in;

   logic [31:0] base_high;
   logic [31:0] base_low;
   logic        base_parity;
   logic [31:0] mul_a;
   logic [31:0] mul_p;

   assign pop = (state_ff == B_IDLE) && head_valid;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_hash_value = hash_ff;

   assign base_high = head_entry.first ? head_entry.start_value : acc_high_ff;
   assign base_low = head_entry.first ? 32'd0 : acc_low_ff;
   assign base_parity = head_entry.first ? 1'b0 : parity_ff;

   // One shared multiplier for the recurrence and the finalizer steps.
   always_comb begin
      if (state_ff == B_FIN) begin
         unique case (step_ff)
            2'd0:    mul_a = fin_high_ff ^ (fin_low_ff >> FIN_SHIFT_A);
            2'd1:    mul_a = fin_low_ff ^ (fin_high_ff >> FIN_SHIFT_B);
            2'd2:    mul_a = fin_high_ff ^ (fin_low_ff >> FIN_SHIFT_C);
            default: mul_a = fin_low_ff ^ (fin_high_ff >> FIN_SHIFT_D);
         endcase
      end else if (head_entry.kind == OP_TAIL) begin
         mul_a = base_low ^ head_entry.operand;
      end else if (!base_parity) begin
         mul_a = base_high;
      end else begin
         mul_a = base_low;
      end
   end

   assign mul_p = mul_a * HASH_MULT;

   always_comb begin
      state_in = state_ff;
      acc_high_in = acc_high_ff;
      acc_low_in = acc_low_ff;
      parity_in = parity_ff;
      fin_high_in = fin_high_ff;
      fin_low_in = fin_low_ff;
      step_in = step_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      hash_in = hash_ff;

      unique case (state_ff)
         B_IDLE: begin
            if (head_valid) begin
               acc_high_in = base_high;
               acc_low_in = base_low;
               parity_in = base_parity;
               unique case (head_entry.kind)
                  OP_FULL: begin
                     if (!base_parity) begin
                        acc_high_in = mul_p ^ head_entry.operand;
                     end else begin
                        acc_low_in = mul_p ^ head_entry.operand;
                     end
                     parity_in = !base_parity;
                  end
                  OP_TAIL: begin
                     acc_low_in = mul_p;
                  end
                  default: begin
                  end
               endcase
               if (head_entry.last) begin
                  fin_high_in = acc_high_in;
                  fin_low_in = acc_low_in;
                  step_in = 2'd0;
                  state_in = B_FIN;
               end
            end
         end
         B_FIN: begin
            if (step_ff[0]) begin
               fin_low_in = mul_p;
            end else begin
               fin_high_in = mul_p;
            end
            step_in = step_ff + 1'b1;
            if (step_ff == LAST_STEP) begin
               state_in = B_EMIT;
            end
         end
         B_EMIT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               hash_in = {fin_high_ff, fin_low_ff};
               state_in = B_IDLE;
            end
         end
         default: begin
            state_in = B_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= B_IDLE;
         acc_high_ff <= '0;
         acc_low_ff <= '0;
         parity_ff <= 1'b0;
         step_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         acc_high_ff <= acc_high_in;
         acc_low_ff <= acc_low_in;
         parity_ff <= parity_in;
         step_ff <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      fin_high_ff <= fin_high_in;
      fin_low_ff <= fin_low_in;
      hash_ff <= hash_in;
   end

   a_fin_to_emit: assert property (@(posedge clock) disable iff (reset)
      (state_ff == B_FIN && step_ff == LAST_STEP) |=> (state_ff == B_EMIT))
      else $error("finalizer did not hand over to emit");

   a_full_toggles_parity: assert property (@(posedge clock) disable iff (reset)
      (pop && head_entry.kind == OP_FULL && !head_entry.first)
      |=> (parity_ff != $past(parity_ff)))
      else $error("full word did not toggle accumulator parity");

   a_acc_hold_in_fin: assert property (@(posedge clock) disable iff (reset)
      (state_ff == B_FIN) |=> ($stable(acc_high_ff) && $stable(acc_low_ff)))
      else $error("accumulators changed during finalization");

   a_rsp_from_emit: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == B_EMIT))
      else $error("result raised outside emit");

endmodule

`default_nettype wire

FILE: hdl/word_stream_hash64.sv
// Top level of the streaming 64-bit word hash: seed register, front, queue, back.
//
//   channel | direction | handshake            | payload
//   req     | in        | req_valid/req_stall  | data_word, byte_count, first/last, length
//   rsp     | out       | rsp_valid/rsp_stall  | hash_value (64)
//   csr     | in        | csr_write_enable     | csr_write_data (seed)
//
// Front captures a word, then runs the first mix multiply while req stalls; the
// second runs at the push, overlapped with the next capture; a full queue holds both.
// Back folds one queued word per cycle while idle; a last word then runs the finalizer
// steps and the emit step; fold and finalizer share one 32x32 multiplier.
// Reset is synchronous: clears queue, state machines, accumulators and seed.
// Stalls on rsp are absorbed by the result register and the queue before req stalls.
`default_nettype none

module word_stream_hash64
   import wsh_pkg::*;
#(
   parameter int unsigned QUEUE_DEPTH = 2
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic [31:0] req_data_word,
   input  wire logic [2:0]  req_byte_count,
   input  wire logic        req_first_item,
   input  wire logic        req_last_item,
   input  wire logic [30:0] req_total_length,
   input  wire logic        req_valid,
   output logic             req_stall,
   output logic [63:0]      rsp_hash_value,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   input  wire logic        csr_write_enable,
   input  wire logic [31:0] csr_write_data
);

   logic [31:0]     seed_ff, seed_in;
   logic            queue_full;
   logic            queue_push;
   queue_entry_type queue_entry;
   logic            queue_pop;
   logic            head_valid;
   queue_entry_type head_entry;

   assign seed_in = csr_write_enable ? csr_write_data : seed_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         seed_ff <= '0;
      end else begin
         seed_ff <= seed_in;
      end
   end

   wsh_front u_front (
      .clock            (clock),
      .reset            (reset),
      .seed             (seed_ff),
      .req_data_word    (req_data_word),
      .req_byte_count   (req_byte_count),
      .req_first_item   (req_first_item),
      .req_last_item    (req_last_item),
      .req_total_length (req_total_length),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .queue_full       (queue_full),
      .queue_push       (queue_push),
      .queue_entry      (queue_entry)
   );

   wsh_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (queue_push),
      .push_entry (queue_entry),
      .full       (queue_full),
      .pop        (queue_pop),
      .head_valid (head_valid),
      .head_entry (head_entry)
   );

   wsh_back u_back (
      .clock          (clock),
      .reset          (reset),
      .head_valid     (head_valid),
      .head_entry     (head_entry),
      .pop            (queue_pop),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_hash_value (rsp_hash_value)
   );

endmodule

`default_nettype wire

FILE: sim/tb_top.sv
// Self-checking testbench for word_stream_hash64: directed and random traffic against a predictor.
`timescale 1ns / 100ps
`default_nettype none

module tb_top
   import wsh_pkg::*;
();

   localparam int unsigned CYCLE_LIMIT = 400000;
   localparam int unsigned SETTLE_CYCLES = 24;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic [31:0] req_data_word = '0;
   logic [2:0]  req_byte_count = '0;
   logic        req_first_item = 1'b0;
   logic        req_last_item = 1'b0;
   logic [30:0] req_total_length = '0;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [63:0] rsp_hash_value;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic        csr_write_enable = 1'b0;
   logic [31:0] csr_write_data = '0;

   int unsigned snd_idle_pct = 0;
   int unsigned rcv_stall_pct = 0;
   int unsigned hold_cycles = 0;
   int unsigned words_sent = 0;
   int unsigned error_count = 0;
   int unsigned cycle_count = 0;

   logic [63:0] pending_hashes[$];

   logic [31:0] seed_q = '0;
   logic [31:0] acc_hi = '0;
   logic [31:0] acc_lo = '0;
   logic        to_low = 1'b0;

   word_stream_hash64 uut (
      .clock            (clock),
      .reset            (reset),
      .req_data_word    (req_data_word),
      .req_byte_count   (req_byte_count),
      .req_first_item   (req_first_item),
      .req_last_item    (req_last_item),
      .req_total_length (req_total_length),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .rsp_hash_value   (rsp_hash_value),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("tb_top: errors");
         $finish;
      end
   end

   // receiver: long hold-off when requested, random stalls otherwise
   always @(negedge clock) begin
      if (hold_cycles > 0) begin
         rsp_stall = 1'b1;
         hold_cycles--;
      end else begin
         rsp_stall = ($urandom_range(99) < rcv_stall_pct);
      end
   end

   always @(posedge clock) begin : check_hash
      logic [63:0] want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_hashes.size() == 0) begin
            $error("hash_value: expected none, actual %h", rsp_hash_value);
            error_count++;
         end else begin
            want = pending_hashes.pop_front();
            if (rsp_hash_value !== want) begin
               $error("hash_value: expected %h, actual %h", want, rsp_hash_value);
               error_count++;
            end
         end
      end
   end

   function automatic logic [31:0] mix32(input logic [31:0] k);
      logic [31:0] r;
      r = k * HASH_MULT;
      r = r ^ (r >> MIX_SHIFT);
      r = r * HASH_MULT;
      return r;
   endfunction

   function automatic logic [63:0] final_hash(input logic [31:0] a, input logic [31:0] b);
      logic [31:0] h1;
      logic [31:0] h2;
      h1 = a;
      h2 = b;
      h1 = (h1 ^ (h2 >> FIN_SHIFT_A)) * HASH_MULT;
      h2 = (h2 ^ (h1 >> FIN_SHIFT_B)) * HASH_MULT;
      h1 = (h1 ^ (h2 >> FIN_SHIFT_C)) * HASH_MULT;
      h2 = (h2 ^ (h1 >> FIN_SHIFT_D)) * HASH_MULT;
      return {h1, h2};
   endfunction

   task automatic absorb_word(input logic [31:0] w, input logic [2:0] cnt, input logic fst,
                              input logic lst, input logic [30:0] len);
      logic [2:0]  nbytes;
      logic [31:0] mask;
      nbytes = (cnt > 3'd4) ? 3'd4 : cnt;
      if (fst) begin
         acc_hi = seed_q ^ {1'b0, len};
         acc_lo = '0;
         to_low = 1'b0;
      end
      if (nbytes == 3'd4) begin
         if (!to_low) acc_hi = (acc_hi * HASH_MULT) ^ mix32(w);
         else acc_lo = (acc_lo * HASH_MULT) ^ mix32(w);
         to_low = ~to_low;
      end else if (nbytes != 3'd0) begin
         mask = (32'h1 << (nbytes * 8)) - 32'h1;
         acc_lo = (acc_lo ^ (w & mask)) * HASH_MULT;
      end
      if (lst) pending_hashes.push_back(final_hash(acc_hi, acc_lo));
   endtask

   task automatic send_word(input logic [31:0] w, input logic [2:0] cnt, input logic fst,
                            input logic lst, input logic [30:0] len);
      @(negedge clock);
      while ($urandom_range(99) < snd_idle_pct) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_data_word = w;
      req_byte_count = cnt;
      req_first_item = fst;
      req_last_item = lst;
      req_total_length = len;
      req_valid = 1'b1;
      do @(posedge clock); while (req_stall);
      absorb_word(w, cnt, fst, lst, len);
      words_sent++;
   endtask

   task automatic wait_drained();
      @(negedge clock);
      req_valid = 1'b0;
      while (pending_hashes.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic set_seed(input logic [31:0] value);
      wait_drained();
      @(negedge clock);
      csr_write_enable = 1'b1;
      csr_write_data = value;
      @(posedge clock);
      seed_q = value;
      @(negedge clock);
      csr_write_enable = 1'b0;
   endtask

   task automatic send_message(input int unsigned nbytes, input logic [30:0] len,
                               input logic with_first, input logic with_last);
      int unsigned full;
      int unsigned rest;
      logic [2:0]  cnt;
      full = nbytes / 4;
      rest = nbytes % 4;
      if (nbytes == 0) begin
         send_word($urandom, 3'd0, with_first, with_last, len);
      end else begin
         for (int unsigned i = 0; i < full; i++) begin
            cnt = ($urandom_range(9) == 0) ? 3'($urandom_range(7, 5)) : 3'd4;
            send_word($urandom, cnt, with_first && i == 0,
                      with_last && rest == 0 && i == full - 1, len);
         end
         if (rest != 0) send_word($urandom, 3'(rest), with_first && full == 0, with_last, len);
      end
   endtask

   task automatic test_reset_state();
      send_word(32'h0000_0000, 3'd0, 1'b0, 1'b1, 31'd0);
      send_word(32'hdead_beef, 3'd4, 1'b0, 1'b0, 31'd0);
      send_word(32'h1234_5678, 3'd0, 1'b0, 1'b1, 31'd0);
      wait_drained();
   endtask

   task automatic test_directed_cases();
      set_seed(32'hffff_ffff);
      send_word(32'h0000_0000, 3'd0, 1'b1, 1'b1, 31'd0);
      // length far from the words that arrive; high bytes beyond the count set
      send_word(32'hffff_ffff, 3'd4, 1'b1, 1'b0, 31'h7fff_ffff);
      send_word(32'hffff_ffff, 3'd3, 1'b0, 1'b1, 31'h7fff_ffff);
      send_word(32'ha5a5_a5a5, 3'd1, 1'b1, 1'b1, 31'd1);
      send_word(32'h5a5a_5a5a, 3'd2, 1'b1, 1'b1, 31'd2);
      send_word(32'hc3c3_c3c3, 3'd3, 1'b1, 1'b1, 31'd3);
      set_seed(32'h0000_0000);
      // counts above four act as a full word
      send_word(32'h8000_0001, 3'd5, 1'b1, 1'b0, 31'd12);
      send_word(32'h7fff_fffe, 3'd6, 1'b0, 1'b0, 31'd12);
      send_word(32'hffff_ffff, 3'd7, 1'b0, 1'b1, 31'd12);
      // tail in the middle of a message
      send_word(32'hff00_ff00, 3'd2, 1'b1, 1'b0, 31'd10);
      send_word(32'h0102_0304, 3'd4, 1'b0, 1'b0, 31'd10);
      send_word(32'hf0e0_d0c0, 3'd4, 1'b0, 1'b1, 31'd10);
      // continue after a last word without a new first word
      send_word(32'h0bad_cafe, 3'd4, 1'b0, 1'b1, 31'd0);
      send_word(32'h0000_0000, 3'd0, 1'b0, 1'b1, 31'h5555_5555);
      send_word(32'h0000_0000, 3'd4, 1'b1, 1'b1, 31'h2aaa_aaaa);
      send_word(32'hffff_ffff, 3'd4, 1'b1, 1'b1, 31'd4);
      wait_drained();
   endtask

   task automatic test_random_traffic(input int unsigned snd_pct, input int unsigned rcv_pct,
                                      input int unsigned n_words);
      int unsigned start;
      int unsigned roll;
      int unsigned nbytes;
      logic [30:0] len;
      snd_idle_pct = snd_pct;
      rcv_stall_pct = rcv_pct;
      start = words_sent;
      while (words_sent - start < n_words) begin
         roll = $urandom_range(99);
         nbytes = ($urandom_range(9) == 0) ? $urandom_range(120) : $urandom_range(24);
         len = ($urandom_range(6) == 0) ? 31'($urandom) : 31'(nbytes);
         if (roll < 80) begin
            send_message(nbytes, len, 1'b1, 1'b1);
         end else if (roll < 88) begin
            send_word($urandom, 3'($urandom_range(7)), $urandom_range(4) == 0,
                      $urandom_range(4) == 0, 31'($urandom));
         end else if (roll < 94) begin
            send_message(nbytes, len, 1'b0, 1'b1);
         end else begin
            send_message(nbytes, len, 1'b1, 1'b0);
         end
      end
      wait_drained();
   endtask

   task automatic test_backpressure();
      snd_idle_pct = 0;
      rcv_stall_pct = 0;
      @(posedge clock);
      hold_cycles = 400;
      for (int i = 0; i < 30; i++) begin
         if (i % 3 == 0) send_message($urandom_range(12), 31'($urandom_range(12)), 1'b1, 1'b1);
         else send_word($urandom, 3'd4, 1'b1, 1'b1, 31'd4);
      end
      // sender pauses until everything is back, then resumes
      wait_drained();
      for (int i = 0; i < 10; i++) send_message($urandom_range(16), 31'($urandom), 1'b1, 1'b1);
      wait_drained();
   endtask

   initial begin
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      test_reset_state();
      test_directed_cases();
      set_seed($urandom);
      test_random_traffic(9, 66, 400);
      set_seed(32'hffff_ffff);
      test_random_traffic(66, 9, 400);
      set_seed($urandom);
      test_random_traffic(0, 0, 400);
      test_backpressure();
      wait_drained();
      if (error_count == 0) begin
         $display("tb_top: clean");
      end else begin
         $display("tb_top: errors");
      end
      $finish;
   end

endmodule

`default_nettype wire
